// File: sv/lvt_pkg.sv
`default_nettype none
package lvt_pkg;

    // number of slots in the recency order
    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int HANDLE_W = 4;
    localparam int MASK_W   = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_TOUCH  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_PICK   = 2'd3
    } t_cmd_e;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_VICTIM  = 2'd1,
        ST_NO_CAND = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status_e;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state_e;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic drop_tail;  // discard least-recent entry (not a candidate)
        logic finish;     // apply update and write response
    } t_dp_cmd_s;

    // datapath to controller
    typedef struct packed {
        t_cmd_e           cmd;
        logic             empty;
        logic             tail_cand;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_dp_sts_s;

endpackage
`default_nettype wire

// File: sv/lvt_if.sv
`default_nettype none
// request channel
interface lvt_req_if import lvt_pkg::*;;
    logic                valid;
    logic                ready;
    t_cmd_e              command;
    logic [HANDLE_W-1:0] handle;
    logic [MASK_W-1:0]   candidate_mask;

    modport source (output valid, command, handle, candidate_mask, input ready);
    modport sink   (input valid, command, handle, candidate_mask, output ready);
endinterface

// response channel
interface lvt_rsp_if import lvt_pkg::*;;
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] victim;
    t_status_e           status;

    modport source (output valid, victim, status, input ready);
    modport sink   (input valid, victim, status, output ready);
endinterface
`default_nettype wire

// File: sv/lru_victim_tracker_unit.sv
// Recency tracker for 16 handle slots: each request inserts, touches or removes a handle,
// or picks the least-recent handle allowed by a candidate mask, and gives exactly one
// response. One request is in flight at a time. Insert, touch and remove finish in the
// execute state after acceptance; pick first discards the non-candidate entries at the
// least-recent end, one per cycle by the tail check of the datapath, before it finishes.
// A held response stalls completion.
`default_nettype none
module lru_victim_tracker_unit import lvt_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lvt_req_if.sink    i_req,
    lvt_rsp_if.source  o_rsp
);

    t_dp_cmd_s dp_cmd;
    t_dp_sts_s dp_sts;

    lvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    lvt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_command   (i_req.command),
        .i_handle    (i_req.handle),
        .i_mask      (i_req.candidate_mask),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_valid     (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_victim    (o_rsp.victim),
        .o_status    (o_rsp.status)
    );

    // a completed request always shows a response next cycle
    a_finish_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |=> o_rsp.valid)
        else $error("finish without response");

    // no second request while one is in flight
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while busy");

    // victim field is zero unless a victim was found
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_VICTIM) |-> (o_rsp.victim == '0))
        else $error("victim set without victim status");

    // order never grows beyond its slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_sts.count <= CNT_W'(ENTRIES))
        else $error("order count out of range");

endmodule
`default_nettype wire

// File: sv/lvt_ctrl.sv
`default_nettype none
module lvt_ctrl import lvt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_dp_sts_s i_sts,
    output t_dp_cmd_s      o_cmd
);

    t_state_e r_state;
    t_state_e n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.drop_tail = 1'b0;
        o_cmd.finish    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // pick walks the tail one entry a cycle until a candidate shows or the order is empty
                if (i_sts.cmd == CMD_PICK && !i_sts.empty && !i_sts.tail_cand) begin
                    o_cmd.drop_tail = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/lvt_dp.sv
`default_nettype none
module lvt_dp import lvt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd_e              i_command,
    input  wire logic [HANDLE_W-1:0] i_handle,
    input  wire logic [MASK_W-1:0]   i_mask,
    input  wire t_dp_cmd_s           i_cmd,
    output t_dp_sts_s                o_sts,
    output logic                     o_valid,
    input  wire logic                i_out_ready,
    output logic [HANDLE_W-1:0]      o_victim,
    output t_status_e                o_status
);

    logic [HANDLE_W-1:0] r_stack [ENTRIES];
    logic [HANDLE_W-1:0] n_stack [ENTRIES];
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    t_cmd_e              r_cmd;
    logic [HANDLE_W-1:0] r_handle;
    logic [MASK_W-1:0]   r_mask;
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_victim;
    t_status_e           r_status;
    logic [HANDLE_W-1:0] n_victim;
    t_status_e           n_status;

    logic [ENTRIES-1:0]  hit;
    logic                present;
    logic [IDX_W-1:0]    pos;
    logic [CNT_W-1:0]    lim;
    logic                full;
    logic                empty;
    logic [IDX_W-1:0]    tail;
    logic [CNT_W-1:0]    count_m1;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_handle <= i_handle;
            r_mask   <= i_mask;
        end
    end

    // per-slot compare against the request handle
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            hit[i] = (CNT_W'(i) < r_count) && (r_stack[i] == r_handle);
        end
    end

    // lowest matching position
    always_comb begin
        pos = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pos = IDX_W'(i);
            end
        end
    end

    assign present  = |hit;
    assign full     = (r_count == CNT_W'(ENTRIES));
    assign empty    = (r_count == '0);
    assign count_m1 = r_count - CNT_W'(1);
    assign tail     = count_m1[IDX_W-1:0];
    // shift limit for push to front: up to the old copy, or the old tail
    assign lim      = present ? CNT_W'(pos) : (full ? CNT_W'(ENTRIES - 1) : r_count);

    // next order and response
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_stack[i] = r_stack[i];
        end
        n_count  = r_count;
        n_victim = '0;
        n_status = ST_DONE;
        if (i_cmd.drop_tail) begin
            n_count = count_m1;
        end else if (i_cmd.finish) begin
            case (r_cmd)
                CMD_INSERT, CMD_TOUCH: begin
                    for (int i = 1; i < ENTRIES; i++) begin
                        if (CNT_W'(i) <= lim) begin
                            n_stack[i] = r_stack[i-1];
                        end
                    end
                    n_stack[0] = r_handle;
                    if (!present && !full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE: begin
                    if (present) begin
                        for (int i = 0; i < ENTRIES - 1; i++) begin
                            if (IDX_W'(i) >= pos) begin
                                n_stack[i] = r_stack[i+1];
                            end
                        end
                        n_count = count_m1;
                    end else begin
                        n_status = ST_ABSENT;
                    end
                end
                CMD_PICK: begin
                    if (empty) begin
                        n_status = ST_NO_CAND;
                    end else begin
                        n_victim = r_stack[tail];
                        n_status = ST_VICTIM;
                        n_count  = count_m1;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // recency order storage
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            r_stack[i] <= n_stack[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_victim <= n_victim;
            r_status <= n_status;
        end
    end

    // status to controller
    assign o_sts.cmd       = r_cmd;
    assign o_sts.empty     = empty;
    assign o_sts.tail_cand = r_mask[r_stack[tail]];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.count     = r_count;

    assign o_valid  = r_out_valid;
    assign o_victim = r_victim;
    assign o_status = r_status;

endmodule
`default_nettype wire
